FILE: hdl/trcrq_pkg.sv
`default_nettype none
package trcrq_pkg;
	localparam int QueueDepth = 16;
	localparam int NumDirs = 5;
	localparam int NumClasses = 3;
	localparam int NumQueues = NumDirs * NumClasses;
	localparam int SlotBits = $clog2(QueueDepth);
	localparam int CountBits = $clog2(QueueDepth + 1);
	localparam int QueueBits = $clog2(NumQueues);

	localparam logic [2:0] DirLocal = 3'd0;
	localparam logic [2:0] DirNorth = 3'd1;
	localparam logic [2:0] DirEast = 3'd2;
	localparam logic [2:0] DirSouth = 3'd3;
	localparam logic [2:0] DirWest = 3'd4;
	localparam logic [1:0] ClassMain = 2'd2;

	localparam logic [2:0] RegMyX = 3'd0;
	localparam logic [2:0] RegMyY = 3'd1;
	localparam logic [2:0] RegWidth = 3'd2;
	localparam logic [2:0] RegHeight = 3'd3;
	localparam logic [2:0] RegAdaptive = 3'd4;

	typedef enum logic [1:0] {
		ACT_ROUTE = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_PEEK = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	// Classified command passed from the front part to the back part.
	typedef struct packed {
		action_t action;
		logic [5:0] vc_id;
		logic at_destination;
		logic escape_valid;
		logic [2:0] escape_dir;
		logic escape_class;
		logic main_x_valid;
		logic [2:0] main_x_dir;
		logic main_y_valid;
		logic [2:0] main_y_dir;
		logic peek_ok;
		logic [QueueBits-1:0] peek_queue;
	} cmd_t;

	// Result of one transaction.
	typedef struct packed {
		logic at_destination;
		logic escape_valid;
		logic [2:0] escape_dir;
		logic escape_class;
		logic main_x_valid;
		logic [2:0] main_x_dir;
		logic main_y_valid;
		logic [2:0] main_y_dir;
		logic queue_full;
		logic peek_valid;
		logic [5:0] peek_vc;
	} result_t;

	function automatic logic [QueueBits-1:0] queue_index(logic [2:0] dir, logic [1:0] cls);
		logic [5:0] q;
		q = {3'd0, dir} * 6'd3 + {4'd0, cls};
		return q[QueueBits-1:0];
	endfunction
endpackage
`default_nettype wire

FILE: hdl/trcrq_classify.sv
`default_nettype none
module trcrq_classify (
	input wire logic [1:0] action,
	input wire logic [5:0] vc_id,
	input wire logic [7:0] dest_x,
	input wire logic [7:0] dest_y,
	input wire logic [7:0] origin_x,
	input wire logic [7:0] origin_y,
	input wire logic [2:0] peek_dir,
	input wire logic [1:0] peek_class,
	input wire logic [7:0] my_x,
	input wire logic [7:0] my_y,
	input wire logic [8:0] ring_width,
	input wire logic [8:0] ring_height,
	input wire logic adaptive_mode,
	output trcrq_pkg::cmd_t cmd
);
	// Signed 11-bit arithmetic covers coordinate plus or minus half a ring.
	logic signed [10:0] tx, ty, hx, hy, dxs, dys, mxs, mys;
	logic x_lt, x_gt, y_lt, y_gt, x_east, y_north, sx_any, sy_any;
	logic local_hit;

	always_comb begin
		hx = $signed({3'd0, ring_width[8:1]});
		hy = $signed({3'd0, ring_height[8:1]});
		dxs = $signed({3'd0, dest_x});
		dys = $signed({3'd0, dest_y});
		mxs = $signed({3'd0, my_x});
		mys = $signed({3'd0, my_y});
		x_lt = dest_x < my_x;
		x_gt = dest_x > my_x;
		y_lt = dest_y < my_y;
		y_gt = dest_y > my_y;
		tx = x_lt ? dxs + hx : dxs - hx;
		ty = y_lt ? dys + hy : dys - hy;
		x_east = tx <= mxs;
		y_north = ty <= mys;
		sx_any = x_lt | x_gt;
		sy_any = y_lt | y_gt;
		local_hit = !sx_any && !sy_any;
	end

	// Decode into the command for the back part.
	always_comb begin
		cmd = '0;
		cmd.vc_id = vc_id;
		unique case (action)
			trcrq_pkg::ACT_ROUTE: begin
				cmd.action = trcrq_pkg::ACT_ROUTE;
				if (local_hit) begin
					cmd.at_destination = 1'b1;
				end else begin
					cmd.escape_valid = 1'b1;
					if (sx_any) begin
						if (x_east) begin
							cmd.escape_dir = trcrq_pkg::DirEast;
							cmd.escape_class = (origin_x > my_x) ||
								({1'b0, my_x} == ring_width - 9'd1);
						end else begin
							cmd.escape_dir = trcrq_pkg::DirWest;
							cmd.escape_class = (origin_x < my_x) || (my_x == 8'd0);
						end
						cmd.main_x_valid = 1'b1;
						cmd.main_x_dir = x_east ? trcrq_pkg::DirEast : trcrq_pkg::DirWest;
					end else if (y_north) begin
						cmd.escape_dir = trcrq_pkg::DirNorth;
						cmd.escape_class = (origin_y > my_y) ||
							({1'b0, my_y} == ring_height - 9'd1);
					end else begin
						cmd.escape_dir = trcrq_pkg::DirSouth;
						cmd.escape_class = (origin_y < my_y) || (my_y == 8'd0);
					end
					if (sy_any && (!sx_any || adaptive_mode)) begin
						cmd.main_y_valid = 1'b1;
						cmd.main_y_dir = y_north ? trcrq_pkg::DirNorth : trcrq_pkg::DirSouth;
					end
				end
			end
			trcrq_pkg::ACT_REMOVE: cmd.action = trcrq_pkg::ACT_REMOVE;
			trcrq_pkg::ACT_PEEK: begin
				cmd.action = trcrq_pkg::ACT_PEEK;
				cmd.peek_ok = (peek_dir < 3'd5) && (peek_class < 2'd3);
				cmd.peek_queue = trcrq_pkg::queue_index(peek_dir, peek_class);
			end
			default: cmd.action = trcrq_pkg::ACT_NONE;
		endcase
	end
endmodule
`default_nettype wire

FILE: hdl/trcrq_cmd_fifo.sv
`default_nettype none
module trcrq_cmd_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire trcrq_pkg::cmd_t push_cmd,
	output logic not_full,
	input wire logic pop,
	output trcrq_pkg::cmd_t pop_cmd,
	output logic not_empty
);
	// Two-entry queue between front and back.
	trcrq_pkg::cmd_t slot_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign not_full = cnt_q != 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign pop_cmd = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && not_full) slot_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && not_full) wr_q <= ~wr_q;
			if (pop && not_empty) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push && not_full} - {1'b0, pop && not_empty};
		end
	end
endmodule
`default_nettype wire

FILE: hdl/trcrq_queues.sv
`default_nettype none
module trcrq_queues (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire trcrq_pkg::cmd_t cmd,
	output logic cmd_ready,
	output logic res_valid,
	input wire logic res_ready,
	output trcrq_pkg::result_t res
);
	localparam int NQ = trcrq_pkg::NumQueues;
	localparam int D = trcrq_pkg::QueueDepth;
	localparam int CB = trcrq_pkg::CountBits;

	logic [5:0] ent_q [NQ][D];
	logic [CB-1:0] cnt_q [NQ];
	logic [NQ-1:0] ins_mask;
	logic full_drop;
	logic [D-1:0] match [NQ];
	logic [D-1:0] keep [NQ];
	logic take;
	trcrq_pkg::result_t res_d;

	// A command executes once the result register is free.
	assign cmd_ready = !res_valid || res_ready;
	assign take = cmd_valid && cmd_ready;

	// Queues written by a route command and drop detection.
	always_comb begin
		ins_mask = '0;
		full_drop = 1'b0;
		if (cmd.action == trcrq_pkg::ACT_ROUTE) begin
			if (cmd.at_destination)
				ins_mask[trcrq_pkg::queue_index(trcrq_pkg::DirLocal, 2'd0)] = 1'b1;
			if (cmd.escape_valid)
				ins_mask[trcrq_pkg::queue_index(cmd.escape_dir, {1'b0, cmd.escape_class})] = 1'b1;
			if (cmd.main_x_valid)
				ins_mask[trcrq_pkg::queue_index(cmd.main_x_dir, trcrq_pkg::ClassMain)] = 1'b1;
			if (cmd.main_y_valid)
				ins_mask[trcrq_pkg::queue_index(cmd.main_y_dir, trcrq_pkg::ClassMain)] = 1'b1;
		end
		for (int q = 0; q < NQ; q++)
			if (ins_mask[q] && cnt_q[q] == CB'(D)) full_drop = 1'b1;
	end

	// Per-queue first-match search for removal; keep marks slots before the hit.
	always_comb begin
		for (int q = 0; q < NQ; q++) begin
			for (int j = 0; j < D; j++)
				match[q][j] = (CB'(j) < cnt_q[q]) && (ent_q[q][j] == cmd.vc_id);
			keep[q] = (match[q] == '0) ? '1 : (match[q] - 1'b1) & ~match[q];
		end
	end

	// Queue storage: append, or delete and compact.
	always_ff @(posedge clk) begin
		if (take) begin
			for (int q = 0; q < NQ; q++) begin
				if (cmd.action == trcrq_pkg::ACT_ROUTE) begin
					if (ins_mask[q] && cnt_q[q] != CB'(D))
						ent_q[q][cnt_q[q][trcrq_pkg::SlotBits-1:0]] <= cmd.vc_id;
				end else if (cmd.action == trcrq_pkg::ACT_REMOVE && match[q] != '0) begin
					for (int j = 0; j < D - 1; j++)
						if (!keep[q][j]) ent_q[q][j] <= ent_q[q][j+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < NQ; q++) cnt_q[q] <= '0;
		end else if (take) begin
			for (int q = 0; q < NQ; q++) begin
				if (cmd.action == trcrq_pkg::ACT_ROUTE) begin
					if (ins_mask[q] && cnt_q[q] != CB'(D)) cnt_q[q] <= cnt_q[q] + 1'b1;
				end else if (cmd.action == trcrq_pkg::ACT_REMOVE && match[q] != '0) begin
					cnt_q[q] <= cnt_q[q] - 1'b1;
				end
			end
		end
	end

	// Result of the command being executed.
	always_comb begin
		res_d = '0;
		if (cmd.action == trcrq_pkg::ACT_ROUTE) begin
			res_d.at_destination = cmd.at_destination;
			res_d.escape_valid = cmd.escape_valid;
			res_d.escape_dir = cmd.escape_dir;
			res_d.escape_class = cmd.escape_class;
			res_d.main_x_valid = cmd.main_x_valid;
			res_d.main_x_dir = cmd.main_x_dir;
			res_d.main_y_valid = cmd.main_y_valid;
			res_d.main_y_dir = cmd.main_y_dir;
			res_d.queue_full = full_drop;
		end else if (cmd.action == trcrq_pkg::ACT_PEEK && cmd.peek_ok &&
				cnt_q[cmd.peek_queue] != '0) begin
			res_d.peek_valid = 1'b1;
			res_d.peek_vc = ent_q[cmd.peek_queue][0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (take) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) res <= res_d;
	end
endmodule
`default_nettype wire

FILE: hdl/torus_route_compute_request_queues.sv
// Route computation with 15 request queues for one 2D torus router.
// Input channel (in_valid/in_ready): one transaction carries a route, remove
// or peek command. The front part classifies it in the accept cycle (local
// match, escape direction with dateline class, main XY or adaptive requests)
// and places it in a two-entry command queue.
// The back part executes one command per cycle while the result register is
// free: appends to the flop queues, deletes the first copy of a VC from each
// queue with compaction, or reads a queue head.
// Output channel (out_valid/out_ready): one result transaction per command.
// An accepted command passes the command queue, then the result register.
// When the receiver stalls, the result register holds, the command queue
// fills, and in_ready drops.
// Reset clears all queue counts and the configuration registers to their
// defaults (width and height 16). Configuration writes go through cfg_we,
// cfg_index and cfg_data and take effect on the next cycle.
`default_nettype none
module torus_route_compute_request_queues (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [8:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] action,
	input wire logic [5:0] vc_id,
	input wire logic [7:0] dest_x,
	input wire logic [7:0] dest_y,
	input wire logic [7:0] origin_x,
	input wire logic [7:0] origin_y,
	input wire logic [2:0] peek_dir,
	input wire logic [1:0] peek_class,
	output logic out_valid,
	input wire logic out_ready,
	output logic at_destination,
	output logic escape_valid,
	output logic [2:0] escape_dir,
	output logic escape_class,
	output logic main_x_valid,
	output logic [2:0] main_x_dir,
	output logic main_y_valid,
	output logic [2:0] main_y_dir,
	output logic queue_full,
	output logic peek_valid,
	output logic [5:0] peek_vc
);
	logic [7:0] my_x_q, my_y_q;
	logic [8:0] width_q, height_q;
	logic adaptive_q;
	trcrq_pkg::cmd_t front_cmd, back_cmd;
	logic back_valid, back_ready;
	trcrq_pkg::result_t res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_x_q <= '0;
			my_y_q <= '0;
			width_q <= 9'd16;
			height_q <= 9'd16;
			adaptive_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				trcrq_pkg::RegMyX: my_x_q <= cfg_data[7:0];
				trcrq_pkg::RegMyY: my_y_q <= cfg_data[7:0];
				trcrq_pkg::RegWidth: width_q <= cfg_data;
				trcrq_pkg::RegHeight: height_q <= cfg_data;
				trcrq_pkg::RegAdaptive: adaptive_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	trcrq_classify u_classify (
		.action(action), .vc_id(vc_id), .dest_x(dest_x), .dest_y(dest_y),
		.origin_x(origin_x), .origin_y(origin_y), .peek_dir(peek_dir),
		.peek_class(peek_class), .my_x(my_x_q), .my_y(my_y_q),
		.ring_width(width_q), .ring_height(height_q),
		.adaptive_mode(adaptive_q), .cmd(front_cmd)
	);

	trcrq_cmd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(in_valid), .push_cmd(front_cmd),
		.not_full(in_ready), .pop(back_ready), .pop_cmd(back_cmd),
		.not_empty(back_valid)
	);

	trcrq_queues u_queues (
		.clk(clk), .arst_n(arst_n), .cmd_valid(back_valid), .cmd(back_cmd),
		.cmd_ready(back_ready), .res_valid(out_valid), .res_ready(out_ready),
		.res(res)
	);

	assign at_destination = res.at_destination;
	assign escape_valid = res.escape_valid;
	assign escape_dir = res.escape_dir;
	assign escape_class = res.escape_class;
	assign main_x_valid = res.main_x_valid;
	assign main_x_dir = res.main_x_dir;
	assign main_y_valid = res.main_y_valid;
	assign main_y_dir = res.main_y_dir;
	assign queue_full = res.queue_full;
	assign peek_valid = res.peek_valid;
	assign peek_vc = res.peek_vc;
endmodule
`default_nettype wire

FILE: sim/torus_route_compute_request_queues_tb.sv
`default_nettype none
module torus_route_compute_request_queues_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Routing decision and queue report of one transaction.
	typedef struct packed {
		logic at_destination;
		logic escape_valid;
		logic [2:0] escape_dir;
		logic escape_class;
		logic main_x_valid;
		logic [2:0] main_x_dir;
		logic main_y_valid;
		logic [2:0] main_y_dir;
		logic queue_full;
		logic peek_valid;
		logic [5:0] peek_vc;
	} route_report_t;

	// Router model with its own queues and configuration, plus the pending reports.
	class route_scoreboard;
		logic [5:0] slots[trcrq_pkg::NumQueues][trcrq_pkg::QueueDepth];
		int fill[trcrq_pkg::NumQueues];
		int pos_x, pos_y, wid, hgt;
		bit adaptive;
		route_report_t pending[$];
		int mismatches;

		function void clear();
			foreach (fill[q]) fill[q] = 0;
			pos_x = 0;
			pos_y = 0;
			wid = 16;
			hgt = 16;
			adaptive = 0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [8:0] val);
			case (idx)
				trcrq_pkg::RegMyX: pos_x = val[7:0];
				trcrq_pkg::RegMyY: pos_y = val[7:0];
				trcrq_pkg::RegWidth: wid = val;
				trcrq_pkg::RegHeight: hgt = val;
				trcrq_pkg::RegAdaptive: adaptive = val[0];
				default: ;
			endcase
		endfunction

		// Appends a VC to a queue; returns 1 when the queue was already full.
		function bit push(logic [2:0] dir, logic [1:0] cls, logic [5:0] vc);
			int q;
			q = dir * trcrq_pkg::NumClasses + cls;
			if (fill[q] >= trcrq_pkg::QueueDepth) return 1;
			slots[q][fill[q]] = vc;
			fill[q]++;
			return 0;
		endfunction

		// 1 for east/north, 0 for west/south, -1 when already aligned.
		function int side(int dest, int here, int size);
			int t;
			if (dest < here) t = dest + size / 2;
			else if (dest > here) t = dest - size / 2;
			else return -1;
			return (t <= here) ? 1 : 0;
		endfunction

		function void note_input(trcrq_pkg::action_t act, logic [5:0] vc, int dx, int dy,
				int ox, int oy, logic [2:0] pdir, logic [1:0] pcls);
			route_report_t r;
			int sx, sy, q, n;
			logic [2:0] d;
			bit c;
			r = '{default: 0};
			if (act == trcrq_pkg::ACT_ROUTE) begin
				if (dx == pos_x && dy == pos_y) begin
					r.queue_full = push(trcrq_pkg::DirLocal, 2'd0, vc);
					r.at_destination = 1;
				end else begin
					sx = side(dx, pos_x, wid);
					sy = side(dy, pos_y, hgt);
					if (sx == 1) begin
						d = trcrq_pkg::DirEast;
						c = (ox > pos_x) || (pos_x == wid - 1);
					end else if (sx == 0) begin
						d = trcrq_pkg::DirWest;
						c = (ox < pos_x) || (pos_x == 0);
					end else if (sy == 1) begin
						d = trcrq_pkg::DirNorth;
						c = (oy > pos_y) || (pos_y == hgt - 1);
					end else begin
						d = trcrq_pkg::DirSouth;
						c = (oy < pos_y) || (pos_y == 0);
					end
					r.queue_full = push(d, {1'b0, c}, vc);
					r.escape_valid = 1;
					r.escape_dir = d;
					r.escape_class = c;
					if (sx >= 0) begin
						r.main_x_dir = (sx == 1) ? trcrq_pkg::DirEast : trcrq_pkg::DirWest;
						r.queue_full |= push(r.main_x_dir, trcrq_pkg::ClassMain, vc);
						r.main_x_valid = 1;
					end
					if (sy >= 0 && (sx < 0 || adaptive)) begin
						r.main_y_dir = (sy == 1) ? trcrq_pkg::DirNorth : trcrq_pkg::DirSouth;
						r.queue_full |= push(r.main_y_dir, trcrq_pkg::ClassMain, vc);
						r.main_y_valid = 1;
					end
				end
			end else if (act == trcrq_pkg::ACT_REMOVE) begin
				// Only the first copy in each queue goes; the rest shifts forward.
				for (q = 0; q < trcrq_pkg::NumQueues; q++) begin
					n = fill[q];
					for (int j = 0; j < n; j++) begin
						if (slots[q][j] == vc) begin
							for (int k = j + 1; k < n; k++) slots[q][k-1] = slots[q][k];
							fill[q] = n - 1;
							break;
						end
					end
				end
			end else if (act == trcrq_pkg::ACT_PEEK) begin
				if (pdir < trcrq_pkg::NumDirs && pcls < trcrq_pkg::NumClasses) begin
					q = pdir * trcrq_pkg::NumClasses + pcls;
					if (fill[q] > 0) begin
						r.peek_valid = 1;
						r.peek_vc = slots[q][0];
					end
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(route_report_t got);
			route_report_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction %p", got);
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				mismatches++;
				if (mismatches <= 10) $display("result mismatch: expected %p actual %p", e, got);
			end
		endfunction
	endclass

	logic clk, arst_n, cfg_we, in_valid, out_ready;
	logic [2:0] cfg_index;
	logic [8:0] cfg_data;
	logic [1:0] action;
	logic [5:0] vc_id;
	logic [7:0] dest_x, dest_y, origin_x, origin_y;
	logic [2:0] peek_dir;
	logic [1:0] peek_class;
	logic in_ready, out_valid;
	route_report_t got;

	torus_route_compute_request_queues u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .vc_id(vc_id), .dest_x(dest_x), .dest_y(dest_y),
		.origin_x(origin_x), .origin_y(origin_y), .peek_dir(peek_dir),
		.peek_class(peek_class), .out_valid(out_valid), .out_ready(out_ready),
		.at_destination(got.at_destination), .escape_valid(got.escape_valid),
		.escape_dir(got.escape_dir), .escape_class(got.escape_class),
		.main_x_valid(got.main_x_valid), .main_x_dir(got.main_x_dir),
		.main_y_valid(got.main_y_valid), .main_y_dir(got.main_y_dir),
		.queue_full(got.queue_full), .peek_valid(got.peek_valid), .peek_vc(got.peek_vc)
	);

	route_scoreboard board = new();
	longint cycles;
	logic [5:0] vc_pool[4];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: random stalls, results checked on the accepting edge.
	initial begin
		int gap;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			@(negedge clk);
			out_ready = (gap == 0);
			while (gap > 0) begin
				@(negedge clk);
				gap--;
				out_ready = (gap == 0);
			end
			do @(posedge clk); while (!out_valid);
			board.check_result(got);
			@(negedge clk);
			out_ready = 0;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [8:0] val);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		board.set_reg(idx, val);
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic wait_drained();
		while (board.pending.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Sends one transaction after a random gap (none in a burst) and notes it once accepted.
	task automatic send(trcrq_pkg::action_t act, logic [5:0] vc, logic [7:0] dx,
			logic [7:0] dy, logic [7:0] ox, logic [7:0] oy, logic [2:0] pd,
			logic [1:0] pc, bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 14);
		repeat (gap) @(negedge clk);
		in_valid = 1;
		action = act;
		vc_id = vc;
		dest_x = dx;
		dest_y = dy;
		origin_x = ox;
		origin_y = oy;
		peek_dir = pd;
		peek_class = pc;
		do @(posedge clk); while (!in_ready);
		board.note_input(act, vc, dx, dy, ox, oy, pd, pc);
		@(negedge clk);
		in_valid = 0;
	endtask

	function automatic logic [7:0] coord(int size, int here);
		case ($urandom_range(0, 5))
			0: return 8'(here);
			1: return 8'd0;
			2: return 8'd255;
			default: return (size > 1) ? 8'($urandom_range(0, size - 1)) :
				8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic random_phase(int count, int wid, int hgt);
		trcrq_pkg::action_t act;
		int pick;
		bit burst;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 19);
			burst = ($urandom_range(0, 7) == 0);
			if (pick < 11) act = trcrq_pkg::ACT_ROUTE;
			else if (pick < 15) act = trcrq_pkg::ACT_REMOVE;
			else if (pick < 19) act = trcrq_pkg::ACT_PEEK;
			else act = trcrq_pkg::ACT_NONE;
			send(act, ($urandom_range(0, 1) != 0) ? vc_pool[$urandom_range(0, 3)] : 6'($urandom),
				coord(wid, board.pos_x), coord(hgt, board.pos_y),
				coord(wid, board.pos_x), coord(hgt, board.pos_y),
				($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4)),
				($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'($urandom_range(0, 2)), burst);
		end
	endtask

	initial begin
		int settings[6][5];
		cycles = 0;
		cfg_we = 0;
		cfg_index = trcrq_pkg::RegMyX;
		cfg_data = 0;
		in_valid = 0;
		action = trcrq_pkg::ACT_ROUTE;
		vc_id = 0;
		dest_x = 0;
		dest_y = 0;
		origin_x = 0;
		origin_y = 0;
		peek_dir = trcrq_pkg::DirLocal;
		peek_class = 0;
		board.clear();
		arst_n = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: local hit, every direction, dateline edges, full queue, peeks, odd actions.
		send(trcrq_pkg::ACT_ROUTE, 6'd5, 8'd0, 8'd0, 8'd0, 8'd0, trcrq_pkg::DirLocal, 0, 0);
		send(trcrq_pkg::ACT_ROUTE, 6'd63, 8'd3, 8'd0, 8'd7, 8'd0, trcrq_pkg::DirLocal, 0, 0);
		send(trcrq_pkg::ACT_ROUTE, 6'd1, 8'd12, 8'd0, 8'd0, 8'd0, trcrq_pkg::DirLocal, 0, 0);
		send(trcrq_pkg::ACT_ROUTE, 6'd2, 8'd0, 8'd4, 8'd0, 8'd9, trcrq_pkg::DirLocal, 0, 0);
		send(trcrq_pkg::ACT_ROUTE, 6'd3, 8'd0, 8'd255, 8'd0, 8'd0, trcrq_pkg::DirLocal, 0, 0);
		send(trcrq_pkg::ACT_ROUTE, 6'd4, 8'd255, 8'd255, 8'd255, 8'd255,
			trcrq_pkg::DirLocal, 0, 0);
		for (int i = 0; i < 17; i++)
			send(trcrq_pkg::ACT_ROUTE, 6'(i), 8'd0, 8'd0, 8'd0, 8'd0, trcrq_pkg::DirLocal, 0, 1);
		send(trcrq_pkg::ACT_PEEK, 0, 0, 0, 0, 0, trcrq_pkg::DirLocal, 0, 0);
		send(trcrq_pkg::ACT_PEEK, 0, 0, 0, 0, 0, trcrq_pkg::DirEast, trcrq_pkg::ClassMain, 0);
		send(trcrq_pkg::ACT_PEEK, 0, 0, 0, 0, 0, 3'd7, 2'd3, 0);
		send(trcrq_pkg::ACT_REMOVE, 6'd5, 0, 0, 0, 0, trcrq_pkg::DirLocal, 0, 0);
		send(trcrq_pkg::ACT_PEEK, 0, 0, 0, 0, 0, trcrq_pkg::DirLocal, 0, 0);
		send(trcrq_pkg::ACT_NONE, 6'd9, 8'd1, 8'd1, 8'd1, 8'd1, trcrq_pkg::DirWest, 2'd1, 0);
		wait_drained();

		// Drain every queue so later phases start from empty queues.
		for (int v = 0; v < 64; v++)
			for (int k = 0; k < 3; k++)
				send(trcrq_pkg::ACT_REMOVE, 6'(v), 0, 0, 0, 0, trcrq_pkg::DirLocal, 0, 1);

		// Register settings: my_x, my_y, width, height, adaptive; extremes included.
		settings = '{'{0, 0, 16, 16, 1}, '{255, 255, 256, 256, 0}, '{7, 3, 8, 4, 1},
			'{0, 0, 1, 1, 0}, '{5, 250, 0, 0, 1}, '{15, 0, 16, 16, 0}};
		for (int s = 0; s < 6; s++) begin
			wait_drained();
			for (int r = 0; r < 5; r++) write_reg(3'(r), 9'(settings[s][r]));
			foreach (vc_pool[k]) vc_pool[k] = 6'($urandom);
			random_phase(260, settings[s][2], settings[s][3]);
			// Sender pause until every result is back, then continue.
			if (s == 2) wait_drained();
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
`default_nettype wire
